// ===== hw/rtl/sor_pkg.sv =====
// Shared types and constants for the spiral order reader.
// Used by sor_walk, spiral_order_reader, sor_checker and tb_top; depends on nothing.
package sor_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEFAULT    = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int ELEM_WIDTH      = 32;
   localparam int CFG_WIDTH       = 7;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_COUNT = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COL_COUNT = CSR_INDEX_WIDTH'(1);

   // Item kind carried in req_tuser
   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_FETCH   = 2'd1,
      MODE_RESTART = 2'd2
   } mode_type;

   // Result status carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_NOT_LOADED = 2'd2
   } status_type;

   // Fetch outcome handed from the walk control to the result path
   typedef struct packed {
      logic       fire;
      logic       last;
      status_type status;
   } fetch_info_type;

endpackage

// ===== hw/rtl/sor_store.sv =====
// Element store of the spiral order reader: one write port, one read port,
// read data registered. Depends on nothing but its parameters.
module sor_store #(
   parameter int DEPTH      = 4096,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sor_walk.sv =====
// Control of the spiral order reader: dimension registers, load counters,
// spiral bounds and walk position; issues store accesses. Uses sor_pkg.
module sor_walk #(
   parameter int MAX_DIM    = sor_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_WIDTH = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_fire,
   input  logic [sor_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sor_pkg::CFG_WIDTH-1:0]       csr_data,
   input  logic                                item_fire,
   input  logic [1:0]                          item_mode,
   output logic                                wr_en,
   output logic [ADDR_WIDTH-1:0]               wr_addr,
   output logic                                rd_en,
   output logic [ADDR_WIDTH-1:0]               rd_addr,
   output sor_pkg::fetch_info_type             fetch_info
);
   import sor_pkg::*;

   // Widths: index into a row or column, dimension, signed bound, counts
   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int BW = DW + 1;
   localparam int EW = (CFG_WIDTH > DW) ? CFG_WIDTH : DW;
   localparam int TW = $clog2(MAX_DIM * MAX_DIM + 1);

   logic [CFG_WIDTH-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [TW-1:0]        load_cnt_ff, load_cnt_in, emit_cnt_ff, emit_cnt_in;
   logic [IW-1:0]        load_row_ff, load_row_in, load_col_ff, load_col_in;
   logic [IW-1:0]        walk_row_ff, walk_row_in, walk_col_ff, walk_col_in;
   logic [1:0]           dir_ff, dir_in;
   logic signed [BW-1:0] top_ff, top_in, bot_ff, bot_in;
   logic signed [BW-1:0] left_ff, left_in, right_ff, right_in;

   logic [DW-1:0]        eff_rows, eff_cols, new_rows, new_cols;
   logic [TW-1:0]        total;
   logic                 restart;
   logic                 loaded;
   logic signed [BW-1:0] walk_row_s, walk_col_s, bound_dec;

   // Register value clamped to MAX_DIM
   function automatic logic [DW-1:0] eff_dim(input logic [CFG_WIDTH-1:0] r);
      logic [DW-1:0] res;
      if (EW'(r) > EW'(MAX_DIM)) begin
         res = DW'(MAX_DIM);
      end else begin
         res = DW'(r);
      end
      return res;
   endfunction

   assign eff_rows = eff_dim(rows_ff);
   assign eff_cols = eff_dim(cols_ff);
   assign total    = TW'(eff_rows) * TW'(eff_cols);
   assign loaded   = (load_cnt_ff >= total);

   assign walk_row_s = $signed(BW'(walk_row_ff));
   assign walk_col_s = $signed(BW'(walk_col_ff));

   // Store addresses, row-major with a stride of MAX_DIM
   assign wr_addr = ADDR_WIDTH'(load_row_ff) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(load_col_ff);
   assign rd_addr = ADDR_WIDTH'(walk_row_ff) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(walk_col_ff);

   // Next state
   always_comb begin
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      load_cnt_in = load_cnt_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      emit_cnt_in = emit_cnt_ff;
      walk_row_in = walk_row_ff;
      walk_col_in = walk_col_ff;
      dir_in      = dir_ff;
      top_in      = top_ff;
      bot_in      = bot_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      restart     = 1'b0;
      bound_dec   = '0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      fetch_info  = '{fire: 1'b0, last: 1'b0, status: ST_OK};

      if (csr_fire) begin
         // Register write, then restart with the new dimensions
         if (csr_index == REG_ROW_COUNT) begin
            rows_in = csr_data;
            restart = 1'b1;
         end else if (csr_index == REG_COL_COUNT) begin
            cols_in = csr_data;
            restart = 1'b1;
         end
      end else if (item_fire) begin
         case (mode_type'(item_mode))
            MODE_WRITE: begin
               if (!loaded) begin
                  wr_en       = 1'b1;
                  load_cnt_in = load_cnt_ff + 1'b1;
                  if ((DW'(load_col_ff) + 1'b1) >= eff_cols) begin
                     load_col_in = '0;
                     load_row_in = load_row_ff + 1'b1;
                  end else begin
                     load_col_in = load_col_ff + 1'b1;
                  end
               end
            end
            MODE_RESTART: begin
               restart = 1'b1;
            end
            MODE_FETCH: begin
               fetch_info.fire = 1'b1;
               if (!loaded) begin
                  fetch_info.status = ST_NOT_LOADED;
               end else if (emit_cnt_ff >= total) begin
                  fetch_info.status = ST_EXHAUSTED;
               end else begin
                  rd_en           = 1'b1;
                  emit_cnt_in     = emit_cnt_ff + 1'b1;
                  fetch_info.last = ((emit_cnt_ff + 1'b1) == total);
                  // Step past the element just read
                  case (dir_ff)
                     2'd0: begin
                        if (walk_col_s < right_ff) begin
                           walk_col_in = walk_col_ff + 1'b1;
                        end else begin
                           top_in      = top_ff + 1'b1;
                           dir_in      = 2'd1;
                           walk_row_in = IW'($unsigned(top_in));
                        end
                     end
                     2'd1: begin
                        if (walk_row_s < bot_ff) begin
                           walk_row_in = walk_row_ff + 1'b1;
                        end else begin
                           bound_dec   = right_ff - 1'b1;
                           right_in    = bound_dec;
                           dir_in      = 2'd2;
                           walk_col_in = bound_dec[BW-1] ? '0 : IW'($unsigned(bound_dec));
                        end
                     end
                     2'd2: begin
                        if (walk_col_s > left_ff) begin
                           walk_col_in = walk_col_ff - 1'b1;
                        end else begin
                           bound_dec   = bot_ff - 1'b1;
                           bot_in      = bound_dec;
                           dir_in      = 2'd3;
                           walk_row_in = bound_dec[BW-1] ? '0 : IW'($unsigned(bound_dec));
                        end
                     end
                     default: begin
                        if (walk_row_s > top_ff) begin
                           walk_row_in = walk_row_ff - 1'b1;
                        end else begin
                           left_in     = left_ff + 1'b1;
                           dir_in      = 2'd0;
                           walk_col_in = IW'($unsigned(left_in));
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      // Restart clears loading and the walk
      if (restart) begin
         new_rows    = eff_dim(rows_in);
         new_cols    = eff_dim(cols_in);
         load_cnt_in = '0;
         load_row_in = '0;
         load_col_in = '0;
         emit_cnt_in = '0;
         walk_row_in = '0;
         walk_col_in = '0;
         dir_in      = 2'd0;
         top_in      = '0;
         left_in     = '0;
         bot_in      = $signed(BW'(new_rows)) - 1'b1;
         right_in    = $signed(BW'(new_cols)) - 1'b1;
      end else begin
         new_rows = '0;
         new_cols = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= CFG_WIDTH'(1);
         cols_ff     <= CFG_WIDTH'(1);
         load_cnt_ff <= '0;
         load_row_ff <= '0;
         load_col_ff <= '0;
         emit_cnt_ff <= '0;
         walk_row_ff <= '0;
         walk_col_ff <= '0;
         dir_ff      <= 2'd0;
         top_ff      <= '0;
         bot_ff      <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         load_cnt_ff <= load_cnt_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         emit_cnt_ff <= emit_cnt_in;
         walk_row_ff <= walk_row_in;
         walk_col_ff <= walk_col_in;
         dir_ff      <= dir_in;
         top_ff      <= top_in;
         bot_ff      <= bot_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
      end
   end

endmodule

// ===== hw/rtl/spiral_order_reader.sv =====
// Spiral order reader: loads a matrix row by row into an element store and
// returns its elements in clockwise spiral order. Uses sor_pkg, sor_store, sor_walk.
//
// Items are taken one per cycle while req_tready is high: write, fetch and
// restart items each touch at most one store word. A fetch result passes
// through the registered store read and then the output register; req_tready
// drops while a fetch waits behind an output that is not being taken, and
// while a configuration write is offered. The store needs no clearing pass
// after reset, and a configuration write to the row or column count
// restarts loading.
module spiral_order_reader #(
   parameter int MAX_DIM    = sor_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = sor_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sor_pkg::ELEM_WIDTH-1:0]      req_tdata,  // [31:0] elem_in
   input  logic [1:0]                          req_tuser,  // [1:0] mode
   // Result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sor_pkg::ELEM_WIDTH-1:0]      rsp_tdata,  // [31:0] elem_out
   output logic                                rsp_tlast,  // is_last
   output logic [1:0]                          rsp_tuser,  // [1:0] status
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sor_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sor_pkg::CFG_WIDTH-1:0]       csr_data
);
   import sor_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (DATA_WIDTH > ELEM_WIDTH) ? DATA_WIDTH : ELEM_WIDTH;

   logic                  item_fire;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic [XW-1:0]         in_ext, rd_ext;
   fetch_info_type        fetch_info;

   // Fetch waiting for its store read
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   status_type            pend_status_ff, pend_status_in;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic [ELEM_WIDTH-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;
   status_type            out_status_ff, out_status_in;
   logic                  out_free, pend_move;

   // A register write takes the cycle; input items wait behind it
   assign out_free   = !out_valid_ff || rsp_tready;
   assign pend_move  = pend_ff && out_free;
   assign req_tready = (!pend_ff || out_free) && !csr_valid;
   assign item_fire  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Element width conversion on the way in and out
   assign in_ext  = XW'(req_tdata);
   assign wr_data = in_ext[DATA_WIDTH-1:0];
   assign rd_ext  = XW'(rd_data);

   sor_walk #(
      .MAX_DIM   (MAX_DIM),
      .ADDR_WIDTH(AW)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item_fire (item_fire),
      .item_mode (req_tuser),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .fetch_info(fetch_info)
   );

   sor_store #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH),
      .ADDR_WIDTH(AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Result path: pending fetch, then output register
   always_comb begin
      pend_in        = pend_ff;
      pend_last_in   = pend_last_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (pend_move) begin
         pend_in       = 1'b0;
         out_valid_in  = 1'b1;
         out_last_in   = pend_last_ff;
         out_status_in = pend_status_ff;
         out_data_in   = (pend_status_ff == ST_OK) ? rd_ext[ELEM_WIDTH-1:0] : '0;
      end
      if (fetch_info.fire) begin
         pend_in        = 1'b1;
         pend_last_in   = fetch_info.last;
         pend_status_in = fetch_info.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      pend_last_ff   <= pend_last_in;
      pend_status_ff <= pend_status_in;
      out_data_ff    <= out_data_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== bench/sor_checker.sv =====
// Result checker for the spiral order reader: tracks shape, load and walk state
// from the accepted items and register writes, and compares every fetch result.
// Depends on sor_pkg for widths, register indexes, modes and status codes.
module sor_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [sor_pkg::ELEM_WIDTH-1:0]      req_tdata,  // [31:0] elem_in
   input  logic [1:0]                          req_tuser,  // [1:0] mode
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [sor_pkg::ELEM_WIDTH-1:0]      rsp_tdata,  // [31:0] elem_out
   input  logic                                rsp_tlast,  // is_last
   input  logic [1:0]                          rsp_tuser,  // [1:0] status
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [sor_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sor_pkg::CFG_WIDTH-1:0]       csr_data,
   output int                                  fail_count,
   output int                                  results_due,
   output int                                  ok_seen,
   output int                                  exhausted_seen,
   output int                                  unloaded_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import sor_pkg::*;

   localparam int DIM = MAX_DIM_DEFAULT;

   typedef enum logic [1:0] {
      GO_RIGHT = 2'd0,
      GO_DOWN  = 2'd1,
      GO_LEFT  = 2'd2,
      GO_UP    = 2'd3
   } heading_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] elem;
      logic                  last;
      status_type            status;
   } fetch_result_type;

   // shape registers and matrix copy
   logic [CFG_WIDTH-1:0]  row_reg, col_reg;
   logic [ELEM_WIDTH-1:0] elem_store [DIM*DIM];

   // load position, spiral bounds and walk position (bounds may go negative)
   int          loaded, load_r, load_c;
   int          top_b, bot_b, left_b, right_b;
   int          walk_r, walk_c, emitted;
   heading_type heading;

   fetch_result_type fetch_results_q [$];
   int fails, n_ok, n_exh, n_unl;

   function automatic int clamp_dim(input logic [CFG_WIDTH-1:0] v);
      return (int'(v) > DIM) ? DIM : int'(v);
   endfunction

   function void restart_walk();
      loaded  = 0;
      load_r  = 0;
      load_c  = 0;
      top_b   = 0;
      left_b  = 0;
      bot_b   = clamp_dim(row_reg) - 1;
      right_b = clamp_dim(col_reg) - 1;
      walk_r  = 0;
      walk_c  = 0;
      heading = GO_RIGHT;
      emitted = 0;
   endfunction

   // step past the element just handed out; turn and shrink at a side's end
   function void step_spiral();
      case (heading)
         GO_RIGHT: begin
            if (walk_c < right_b) walk_c++;
            else begin
               top_b++;
               heading = GO_DOWN;
               walk_r  = top_b;
            end
         end
         GO_DOWN: begin
            if (walk_r < bot_b) walk_r++;
            else begin
               right_b--;
               heading = GO_LEFT;
               walk_c  = (right_b < 0) ? 0 : right_b;
            end
         end
         GO_LEFT: begin
            if (walk_c > left_b) walk_c--;
            else begin
               bot_b--;
               heading = GO_UP;
               walk_r  = (bot_b < 0) ? 0 : bot_b;
            end
         end
         default: begin
            if (walk_r > top_b) walk_r--;
            else begin
               left_b++;
               heading = GO_RIGHT;
               walk_c  = left_b;
            end
         end
      endcase
   endfunction

   // apply one accepted item; a fetch queues the result it must produce
   function void apply_item(input logic [1:0] m, input logic [ELEM_WIDTH-1:0] d);
      fetch_result_type res;
      int total;
      total = clamp_dim(row_reg) * clamp_dim(col_reg);
      case (m)
         MODE_WRITE: begin
            if (loaded < total) begin
               elem_store[(load_r % DIM) * DIM + (load_c % DIM)] = d;
               loaded++;
               load_c++;
               if (load_c >= clamp_dim(col_reg)) begin
                  load_c = 0;
                  load_r++;
               end
            end
         end
         MODE_RESTART: restart_walk();
         MODE_FETCH: begin
            res = '0;
            if (loaded < total) res.status = ST_NOT_LOADED;
            else if (emitted >= total) res.status = ST_EXHAUSTED;
            else begin
               res.elem = elem_store[(walk_r % DIM) * DIM + (walk_c % DIM)];
               emitted++;
               res.last   = (emitted == total);
               res.status = ST_OK;
               step_spiral();
            end
            fetch_results_q.insert(fetch_results_q.size(), res);
         end
         default: ;  // unused mode: no effect, no result
      endcase
   endfunction

   // results first: a result never belongs to an item accepted at the same edge
   always @(posedge clock) begin
      fetch_result_type want;
      if (reset) begin
         row_reg = 7'd1;
         col_reg = 7'd1;
         restart_walk();
         fetch_results_q.delete();
         fails = 0;
         n_ok  = 0;
         n_exh = 0;
         n_unl = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fetch_results_q.size() == 0) begin
               $error("unexpected result item: elem_out %h is_last %0d status %0d",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               fails++;
            end else begin
               want = fetch_results_q.pop_front();
               if (rsp_tdata !== want.elem) begin
                  $error("elem_out: expected %h, got %h", want.elem, rsp_tdata);
                  fails++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("is_last: expected %0d, got %0d", want.last, rsp_tlast);
                  fails++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fails++;
               end
               case (want.status)
                  ST_OK:        n_ok++;
                  ST_EXHAUSTED: n_exh++;
                  default:      n_unl++;
               endcase
            end
         end
         // a register write stores the count and restarts loading
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROW_COUNT) begin
               row_reg = csr_data;
               restart_walk();
            end else if (csr_index == REG_COL_COUNT) begin
               col_reg = csr_data;
               restart_walk();
            end
         end
         if (req_tvalid && req_tready) apply_item(req_tuser, req_tdata);
      end
      fail_count     <= fails;
      results_due    <= fetch_results_q.size();
      ok_seen        <= n_ok;
      exhausted_seen <= n_exh;
      unloaded_seen  <= n_unl;
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the spiral order reader bench: clock, reset, item and register stimulus,
// receiver stalls, watchdog and verdict. Uses sor_pkg, spiral_order_reader, sor_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sor_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 6;
   localparam int         DIM            = MAX_DIM_DEFAULT;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [ELEM_WIDTH-1:0]      req_tdata  = '0;
   logic [1:0]                 req_tuser  = MODE_WRITE;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [ELEM_WIDTH-1:0]      rsp_tdata;
   logic                       rsp_tlast;
   logic [1:0]                 rsp_tuser;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = REG_ROW_COUNT;
   logic [CFG_WIDTH-1:0]       csr_data   = '0;

   int chk_fail_count, chk_results_due, chk_ok, chk_exhausted, chk_unloaded;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   int shapes_run    = 0;
   int shape_total   = 1;
   int idle_run      = 0;

   always #4 clock = ~clock;

   spiral_order_reader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sor_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (chk_fail_count),
      .results_due    (chk_results_due),
      .ok_seen        (chk_ok),
      .exhausted_seen (chk_exhausted),
      .unloaded_seen  (chk_unloaded)
   );

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: cycles in a row with no item moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_run <= 0;
      else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else
         idle_run <= idle_run + 1;
   end

   // one input item, now and then with a random gap before it
   task automatic push_item(input logic [1:0] m, input logic [ELEM_WIDTH-1:0] d);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (m != MODE_UNUSED) items_sent++;
   endtask

   // hold off until every fetch result is back and the block has settled
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk_results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] val);
      wait_results_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(input logic [CFG_WIDTH-1:0] rows, input logic [CFG_WIDTH-1:0] cols);
      write_reg(REG_ROW_COUNT, rows);
      write_reg(REG_COL_COUNT, cols);
      shape_total = ((rows > DIM) ? DIM : int'(rows)) * ((cols > DIM) ? DIM : int'(cols));
      shapes_run++;
   endtask

   // element values lean on the extremes
   function automatic logic [ELEM_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // load the whole matrix, then walk it; with noise, early fetches, unused
   // modes, restarts mid-load or mid-walk, extra writes and full pauses
   task automatic run_matrix(input int total, input bit noisy);
      int placed;
      int fetches;
      bit broken;
      placed = 0;
      broken = 1'b0;
      while (placed < total) begin
         if (noisy && $urandom_range(99) < 8) begin
            case ($urandom_range(3))
               0: push_item(MODE_FETCH, $urandom);
               1: push_item(MODE_UNUSED, $urandom);
               2: begin
                  push_item(MODE_RESTART, $urandom);
                  placed = 0;
               end
               default: wait_results_drained();
            endcase
         end else begin
            push_item(MODE_WRITE, pick_value());
            placed++;
         end
      end
      if (noisy && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) push_item(MODE_WRITE, pick_value());
      fetches = total + $urandom_range(1, 2);
      while (fetches > 0 && !broken) begin
         if (noisy && $urandom_range(99) < 3) begin
            push_item(MODE_RESTART, $urandom);
            broken = 1'b1;
         end else begin
            if (noisy && $urandom_range(99) < 5) push_item(MODE_UNUSED, $urandom);
            if (noisy && $urandom_range(99) < 5) push_item(MODE_WRITE, pick_value());
            push_item(MODE_FETCH, $urandom);
            fetches--;
         end
      end
   endtask

   // mostly empty, full-length-side or clamped-count shapes; small shapes otherwise
   task automatic pick_shape();
      case ($urandom_range(9))
         0:       set_shape(7'd0, 7'($urandom_range(0, 5)));
         1:       set_shape(7'($urandom_range(1, 4)), 7'd0);
         2:       set_shape(7'd64, 7'($urandom_range(1, 2)));
         3:       set_shape(7'($urandom_range(1, 2)), 7'd64);
         4:       set_shape(7'($urandom_range(65, 127)), 7'($urandom_range(1, 2)));
         5:       set_shape(7'($urandom_range(1, 2)), 7'($urandom_range(65, 127)));
         default: set_shape(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
      endcase
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset shape 1x1, early fetch, exhaustion, extra write, unused mode
      push_item(MODE_FETCH, 32'h0);
      push_item(MODE_WRITE, 32'h8000_0000);
      push_item(MODE_FETCH, 32'hFFFF_FFFF);
      push_item(MODE_FETCH, 32'h0);
      push_item(MODE_UNUSED, 32'hFFFF_FFFF);
      push_item(MODE_WRITE, 32'h7FFF_FFFF);
      push_item(MODE_FETCH, 32'h0);
      push_item(MODE_RESTART, 32'h0);
      push_item(MODE_WRITE, 32'hFFFF_FFFF);
      push_item(MODE_FETCH, 32'h0);
      // zero-sized matrix is exhausted at once and ignores writes
      set_shape(7'd0, 7'd5);
      push_item(MODE_FETCH, 32'h0);
      push_item(MODE_WRITE, 32'h1234_5678);
      push_item(MODE_FETCH, 32'h0);
      // 2x3 walk with a fetch in the middle of loading
      set_shape(7'd2, 7'd3);
      push_item(MODE_WRITE, 32'h0000_0000);
      push_item(MODE_WRITE, 32'h0000_0001);
      push_item(MODE_WRITE, 32'hFFFF_FFFF);
      push_item(MODE_FETCH, 32'h0);
      push_item(MODE_WRITE, 32'h7FFF_FFFF);
      push_item(MODE_WRITE, 32'h8000_0000);
      push_item(MODE_WRITE, 32'h0000_0006);
      repeat (7) push_item(MODE_FETCH, 32'h0);

      // random: three stall profiles, about 300 items each
      for (int phase = 0; phase < 3; phase++) begin
         wait_results_drained();
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (items_sent < 300 * (phase + 1) + 30) begin
            if ($urandom_range(2) == 0) pick_shape();
            else push_item(MODE_RESTART, $urandom);
            run_matrix(shape_total, 1'b1);
         end
      end

      wait_results_drained();
      $display("Covered %0d items over %0d shapes: empty, single, clamped and long-side spirals.",
               items_sent, shapes_run);
      $display("Fetch results checked: %0d ok, %0d exhausted, %0d not loaded.",
               chk_ok, chk_exhausted, chk_unloaded);
      if (chk_fail_count == 0 && chk_results_due == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
